// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl, clocked on clk_i and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define A3HT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define A3HT_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== design/a3ht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a3ht_pkg
// Types and constants of the A3 handover trigger.
// ----------------------------------------------------------------------------
package a3ht_pkg;

  localparam int unsigned NUM_CELLS_DEF = 8;

  localparam int unsigned CellW  = 3;
  localparam int unsigned RsrpW  = 11;
  localparam int unsigned HystW  = 8;
  localparam int unsigned TttW   = 8;
  localparam int unsigned CntW   = 10;
  localparam int unsigned EvW    = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic signed [RsrpW-1:0] DROP_THR_RST = -11'sd480;
  localparam logic [HystW-1:0]        HYST_RST     = 8'd12;
  localparam logic [TttW-1:0]         TTT_RST      = 8'd4;

  // floor of the strongest-cell search, below every storable value
  localparam logic signed [RsrpW:0]   SEARCH_FLOOR = -12'sd1200;

  typedef enum logic [EvW-1:0] {
    EV_NONE    = 3'd0,
    EV_DROP    = 3'd1,
    EV_DROP_HO = 3'd2,
    EV_ARMED   = 3'd3,
    EV_HO_REP  = 3'd4,
    EV_CANCEL  = 3'd5
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DROP_THR = 2'd0,
    CFG_HYST     = 2'd1,
    CFG_TTT      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                   armed;
    logic signed [CntW-1:0] countdown;
  } trig_entry_t;

endpackage

// ===== design/a3ht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a3ht_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module a3ht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/a3_handover_trigger_with_ttt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a3_handover_trigger_with_ttt
// LTE A3 handover check with time to trigger over per-cell stored strengths.
// ----------------------------------------------------------------------------
// usage
//   an item (operation, cell, rsrp) is taken when start is high and busy low;
//   exactly one result beat follows, shown for one cycle with done_o high.
//   configuration is to be written over cfg_valid_i/cfg_ready_o while the
//   block is idle, a user duty the block does not enforce; cfg_ready_o is
//   always high and an index beyond the list is dropped.
// sequence
//   handover done or unreachable cell: result decided in the read state;
//   measurement report: stored in the read state, result decided in eval;
//   call drop: after eval, a strongest-cell walk reads the strength RAM one
//   entry a cycle; one item at a time; busy drops in the cycle the result is
//   shown, so the next item can be taken while done_o is high
// reset
//   strengths read as zero, all triggers clear, serving cell 0, registers at
//   their defaults; valid bits stand in for clearing the RAMs, so no sweep
//   is needed and the block is ready in the first cycle after reset
// the receiver cannot stall, results are never held
// ----------------------------------------------------------------------------
module a3_handover_trigger_with_ttt #(
  parameter int unsigned NUM_CELLS = a3ht_pkg::NUM_CELLS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   operation_i,
  input  logic [a3ht_pkg::CellW-1:0]             cell_req_i,
  input  logic signed [a3ht_pkg::RsrpW-1:0]      rsrp_i,
  output logic                                   done_o,
  output logic [a3ht_pkg::EvW-1:0]               event_code_o,
  output logic [a3ht_pkg::CellW-1:0]             target_cell_o,
  output logic [a3ht_pkg::CellW-1:0]             serving_cell_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [a3ht_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [a3ht_pkg::CfgDataW-1:0]          cfg_data_i
);
  import a3ht_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CW        = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int unsigned CELL_SPAN = (NUM_CELLS < 8) ? NUM_CELLS : 8;
  localparam int unsigned SW        = $clog2(CELL_SPAN + 1);
  localparam logic [3:0]  SPAN_W    = 4'(CELL_SPAN);
  localparam logic [SW-1:0] SCAN_END = SW'(CELL_SPAN);
  localparam int unsigned TW        = $bits(trig_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_SCAN = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic                      op_q, op_d;
  logic [CellW-1:0]          cell_q, cell_d;
  logic signed [RsrpW-1:0]   rsrp_q, rsrp_d;
  logic signed [RsrpW-1:0]   thr_q;
  logic [HystW-1:0]          hyst_q;
  logic [TttW-1:0]           ttt_q;
  logic [CellW-1:0]          serving_q, serving_d;
  logic                      pending_q, pending_d;
  logic [TttW-1:0]           clr_val_q, clr_val_d;
  logic [NUM_CELLS-1:0]      rsrp_vld_q, rsrp_vld_d;
  logic [NUM_CELLS-1:0]      trig_vld_q, trig_vld_d;
  logic                      rsrp_rvld_q, rsrp_rvld_d;
  logic                      trig_rvld_q, trig_rvld_d;
  logic [SW-1:0]             cnt_q, cnt_d;
  logic                      scan_vld_q, scan_vld_d;
  logic [CellW-1:0]          cmp_id_q, cmp_id_d;
  logic signed [RsrpW:0]     best_q, best_d;
  logic [CellW-1:0]          best_id_q, best_id_d;
  logic                      done_q, done_d;
  event_e                    ev_q, ev_d;
  logic [CellW-1:0]          tgt_q, tgt_d;
  logic [CellW-1:0]          srv_out_q, srv_out_d;

  logic                      in_range;
  logic [CW-1:0]             cell_addr;
  logic                      rsrp_we;
  logic [CW-1:0]             rsrp_raddr;
  logic [RsrpW-1:0]          rsrp_rdata;
  logic                      trig_we;
  trig_entry_t               trig_wdata;
  logic [TW-1:0]             trig_rdata;
  logic                      clr_all;

  trig_entry_t               entry;
  logic signed [RsrpW-1:0]   stored_rsrp;
  logic signed [RsrpW+1:0]   serv_plus_hyst;
  logic                      better;
  logic signed [CntW-1:0]    ttt_m1;
  logic                      scan_win;
  logic [CellW-1:0]          scan_pick;

  assign in_range  = {1'b0, cell_q} < SPAN_W;
  assign cell_addr = CW'(cell_q);

  a3ht_ram #(
    .WIDTH (RsrpW),
    .DEPTH (NUM_CELLS)
  ) u_rsrp_ram (
    .clk_i   (clk_i),
    .we_i    (rsrp_we),
    .waddr_i (cell_addr),
    .wdata_i (rsrp_q),
    .raddr_i (rsrp_raddr),
    .rdata_o (rsrp_rdata)
  );

  a3ht_ram #(
    .WIDTH (TW),
    .DEPTH (NUM_CELLS)
  ) u_trig_ram (
    .clk_i   (clk_i),
    .we_i    (trig_we),
    .waddr_i (cell_addr),
    .wdata_i (trig_wdata),
    .raddr_i (cell_addr),
    .rdata_o (trig_rdata)
  );

  // an unwritten strength reads zero, a trigger disarmed with last clear's ttt
  assign stored_rsrp = rsrp_rvld_q ? $signed(rsrp_rdata) : '0;
  assign entry = trig_rvld_q ? trig_entry_t'(trig_rdata)
                             : trig_entry_t'({1'b0, 2'b00, clr_val_q});

  assign serv_plus_hyst = {{2{stored_rsrp[RsrpW-1]}}, stored_rsrp}
                        + $signed({5'b0_0000, hyst_q});
  assign better = $signed({{2{rsrp_q[RsrpW-1]}}, rsrp_q}) >= serv_plus_hyst;
  assign ttt_m1 = $signed({2'b00, ttt_q}) - 10'sd1;

  assign scan_win  = scan_vld_q &&
                     ($signed({stored_rsrp[RsrpW-1], stored_rsrp}) > best_q);
  assign scan_pick = scan_win ? cmp_id_q : best_id_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cell_d      = cell_q;
    rsrp_d      = rsrp_q;
    serving_d   = serving_q;
    pending_d   = pending_q;
    cnt_d       = cnt_q;
    scan_vld_d  = 1'b0;
    cmp_id_d    = cmp_id_q;
    best_d      = best_q;
    best_id_d   = best_id_q;
    done_d      = 1'b0;
    ev_d        = ev_q;
    tgt_d       = tgt_q;
    srv_out_d   = srv_out_q;
    rsrp_we     = 1'b0;
    rsrp_raddr  = CW'(serving_q);
    trig_we     = 1'b0;
    trig_wdata  = '0;
    clr_all     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d    = operation_i;
          cell_d  = cell_req_i;
          rsrp_d  = rsrp_i;
          state_d = ST_READ;
        end
      end

      ST_READ: begin
        if (!in_range) begin
          done_d    = 1'b1;
          ev_d      = EV_NONE;
          tgt_d     = cell_q;
          srv_out_d = serving_q;
          state_d   = ST_IDLE;
        end else if (op_q) begin
          serving_d = cell_q;
          pending_d = 1'b0;
          done_d    = 1'b1;
          ev_d      = EV_NONE;
          tgt_d     = cell_q;
          srv_out_d = cell_q;
          state_d   = ST_IDLE;
        end else begin
          // store the report; serving strength and trigger entry come back next
          rsrp_we = 1'b1;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        done_d    = 1'b1;
        ev_d      = EV_NONE;
        tgt_d     = cell_q;
        srv_out_d = serving_q;
        state_d   = ST_IDLE;
        if (cell_q == serving_q) begin
          if (rsrp_q < thr_q) begin
            done_d    = 1'b0;
            cnt_d     = '0;
            best_d    = SEARCH_FLOOR;
            best_id_d = '0;
            state_d   = ST_SCAN;
          end
        end else if (!pending_q) begin
          if (!entry.armed) begin
            if (better) begin
              trig_we    = 1'b1;
              trig_wdata = '{armed: 1'b1, countdown: entry.countdown};
              ev_d       = EV_ARMED;
            end
          end else if (entry.countdown <= 10'sd0) begin
            trig_we    = 1'b1;
            trig_wdata = '{armed: 1'b0, countdown: ttt_m1};
            if (better) begin
              ev_d      = EV_HO_REP;
              clr_all   = 1'b1;
              pending_d = 1'b1;
            end else begin
              ev_d = EV_CANCEL;
            end
          end else begin
            trig_we    = 1'b1;
            trig_wdata = '{armed: 1'b1, countdown: entry.countdown - 10'sd1};
          end
        end
      end

      ST_SCAN: begin
        // read one entry a cycle, compare it the cycle after
        rsrp_raddr = CW'(cnt_q);
        cmp_id_d   = CellW'(cnt_q);
        if (scan_win) begin
          best_d    = {stored_rsrp[RsrpW-1], stored_rsrp};
          best_id_d = cmp_id_q;
        end
        if (cnt_q != SCAN_END) begin
          scan_vld_d = 1'b1;
          cnt_d      = cnt_q + SW'(1);
        end else begin
          serving_d = scan_pick;
          pending_d = 1'b0;
          clr_all   = 1'b1;
          done_d    = 1'b1;
          ev_d      = pending_q ? EV_DROP_HO : EV_DROP;
          tgt_d     = cell_q;
          srv_out_d = scan_pick;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsrp_vld_d = rsrp_vld_q;
    trig_vld_d = trig_vld_q;
    clr_val_d  = clr_val_q;
    if (rsrp_we) begin
      rsrp_vld_d[cell_addr] = 1'b1;
    end
    if (clr_all) begin
      trig_vld_d = '0;
      clr_val_d  = ttt_q;
    end
    if (trig_we) begin
      trig_vld_d[cell_addr] = 1'b1;
    end
    rsrp_rvld_d = rsrp_vld_q[rsrp_raddr];
    trig_rvld_d = trig_vld_q[cell_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= DROP_THR_RST;
      hyst_q      <= HYST_RST;
      ttt_q       <= TTT_RST;
      serving_q   <= '0;
      pending_q   <= 1'b0;
      clr_val_q   <= TTT_RST;
      rsrp_vld_q  <= '0;
      trig_vld_q  <= '0;
      rsrp_rvld_q <= 1'b0;
      trig_rvld_q <= 1'b0;
      cnt_q       <= '0;
      scan_vld_q  <= 1'b0;
      done_q      <= 1'b0;
      ev_q        <= EV_NONE;
      tgt_q       <= '0;
      srv_out_q   <= '0;
    end else begin
      state_q     <= state_d;
      serving_q   <= serving_d;
      pending_q   <= pending_d;
      clr_val_q   <= clr_val_d;
      rsrp_vld_q  <= rsrp_vld_d;
      trig_vld_q  <= trig_vld_d;
      rsrp_rvld_q <= rsrp_rvld_d;
      trig_rvld_q <= trig_rvld_d;
      cnt_q       <= cnt_d;
      scan_vld_q  <= scan_vld_d;
      done_q      <= done_d;
      ev_q        <= ev_d;
      tgt_q       <= tgt_d;
      srv_out_q   <= srv_out_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DROP_THR: thr_q  <= $signed(cfg_data_i[RsrpW-1:0]);
          CFG_HYST:     hyst_q <= cfg_data_i[HystW-1:0];
          CFG_TTT:      ttt_q  <= cfg_data_i[TttW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // item payload and search registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    cell_q    <= cell_d;
    rsrp_q    <= rsrp_d;
    cmp_id_q  <= cmp_id_d;
    best_q    <= best_d;
    best_id_q <= best_id_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign event_code_o   = ev_q;
  assign target_cell_o  = tgt_q;
  assign serving_cell_o = srv_out_q;

  `A3HT_ASSERT(a_done_after_work, done_o |-> $past(busy))
  `A3HT_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy)
  `A3HT_ASSERT_NEVER(a_serving_reachable, 4'(serving_q) >= SPAN_W)
  `A3HT_ASSERT(a_drop_ends_pending, (done_o && (event_code_o == EV_DROP_HO)) |-> !pending_q)

endmodule
